// ----- sv/pbht_pkg.sv -----
// Shared types and constants for the packet buffer head/tail engine.
// No dependencies; the interfaces, the top level, the store and the bench use this package.
package pbht_pkg;

  localparam int DATA_W      = 48;
  localparam int CNT_W       = 8;
  localparam int POS_W       = 11;
  localparam int HR_W        = 12;
  localparam int LEN_OUT_W   = 12;
  localparam int NBANK       = 8;
  localparam int BANK_SEL_W  = 3;
  localparam int NBYTE_W     = 3;
  localparam logic [HR_W-1:0] HEADROOM_RST = 12'd64;

  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_PUSH   = 3'd1,
    CMD_APPEND = 3'd2,
    CMD_POKE   = 3'd3,
    CMD_POP    = 3'd4,
    CMD_READ   = 3'd5,
    CMD_SKIP   = 3'd6
  } cmd_e_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // Access request to the banked byte store
  typedef struct packed {
    logic               wr;
    logic               rd;
    logic [NBYTE_W-1:0] nbytes;
  } store_req_t;

  function automatic logic size_ok(input logic [CNT_W-1:0] n);
    return (n == 8'd1) || (n == 8'd2) || (n == 8'd4) || (n == 8'd6);
  endfunction

endpackage

// ----- sv/pbht_if.sv -----
// Valid/ready channel interfaces for command transactions and results.
// Depends on pbht_pkg for field widths.
interface pbht_in_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    cmd;
  logic [pbht_pkg::CNT_W-1:0]    byte_count;
  logic [pbht_pkg::DATA_W-1:0]   write_data;
  logic [pbht_pkg::POS_W-1:0]    position;

  modport source (output valid, cmd, byte_count, write_data, position, input ready);
  modport sink   (input valid, cmd, byte_count, write_data, position, output ready);
endinterface

interface pbht_out_if;
  logic                            valid;
  logic                            ready;
  logic [pbht_pkg::DATA_W-1:0]     read_data;
  logic                            error;
  logic [pbht_pkg::LEN_OUT_W-1:0]  room_left;
  logic [pbht_pkg::LEN_OUT_W-1:0]  msg_length;

  modport source (output valid, read_data, error, room_left, msg_length, input ready);
  modport sink   (input valid, read_data, error, room_left, msg_length, output ready);
endinterface

// ----- sv/packet_buffer_head_tail_engine_top.sv -----
// Packet buffer with headroom: one message in a byte store, addressed by head
// and length. Each command transaction passes through IDLE, which decodes,
// checks bounds and issues the bank writes or reads, and then EXEC, which
// collects the registered read data of the eight-bank store and loads the
// result register. A new transaction is accepted while the previous result
// still waits; EXEC stalls only while that result is not taken. Depends on
// pbht_pkg, pbht_if, pbht_store.
module packet_buffer_head_tail_engine_top #(
  parameter int BUF_BYTES = 2048
) (
  input  logic                    clk,
  input  logic                    rst_n,
  pbht_in_if.sink                 in_ch,
  pbht_out_if.source              out_ch,
  input  logic                    cfg_we,
  input  logic [pbht_pkg::HR_W-1:0] cfg_wdata
);
  import pbht_pkg::*;

  localparam int AW = $clog2(BUF_BYTES);
  localparam int CW = $clog2(BUF_BYTES + 1);
  localparam int EW = ((CW > HR_W) ? CW : HR_W) + 1;
  localparam logic [EW-1:0] BUF_E    = EW'(BUF_BYTES);
  localparam int            HEAD_RST = (BUF_BYTES < 64) ? BUF_BYTES : 64;

  state_t             state_r, state_nxt;
  logic [HR_W-1:0]    headroom_r;
  logic [CW-1:0]      head_r, len_r;
  logic               pend_rd_r, pend_err_r;
  logic               out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]  out_rd_r;
  logic               out_err_r;
  logic [LEN_OUT_W-1:0] out_room_r, out_len_r;

  logic               accept, out_load;
  logic               dec_err;
  logic [EW-1:0]      head_e, len_e, n_e, pos_e, tail_e, hr_e;
  logic [EW-1:0]      head_n, len_n, addr_e;
  store_req_t         req;
  logic [DATA_W-1:0]  store_q;

  assign head_e = EW'(head_r);
  assign len_e  = EW'(len_r);
  assign n_e    = EW'(in_ch.byte_count);
  assign pos_e  = EW'(in_ch.position);
  assign tail_e = head_e + len_e;
  assign hr_e   = EW'(headroom_r);

  // Command decode and bound checks
  always_comb begin
    dec_err    = 1'b0;
    req.wr     = 1'b0;
    req.rd     = 1'b0;
    req.nbytes = in_ch.byte_count[NBYTE_W-1:0];
    addr_e     = head_e;
    head_n     = head_e;
    len_n      = len_e;
    case (cmd_e_t'(in_ch.cmd))
      CMD_CLEAR: begin
        head_n = (hr_e > BUF_E) ? BUF_E : hr_e;
        len_n  = '0;
      end
      CMD_PUSH: begin
        dec_err = !size_ok(in_ch.byte_count) || (head_e < n_e);
        addr_e  = head_e - n_e;
        head_n  = head_e - n_e;
        len_n   = len_e + n_e;
        req.wr  = 1'b1;
      end
      CMD_APPEND: begin
        dec_err = !size_ok(in_ch.byte_count) || (tail_e + n_e > BUF_E);
        addr_e  = tail_e;
        len_n   = len_e + n_e;
        req.wr  = 1'b1;
      end
      CMD_POKE: begin
        dec_err = !size_ok(in_ch.byte_count) || (pos_e + n_e > len_e);
        addr_e  = head_e + pos_e;
        req.wr  = 1'b1;
      end
      CMD_POP: begin
        dec_err = !size_ok(in_ch.byte_count) || (len_e < n_e);
        head_n  = head_e + n_e;
        len_n   = len_e - n_e;
        req.rd  = 1'b1;
      end
      CMD_READ: begin
        dec_err = !size_ok(in_ch.byte_count) || (pos_e + n_e > len_e);
        addr_e  = head_e + pos_e;
        req.rd  = 1'b1;
      end
      CMD_SKIP: begin
        dec_err = len_e < n_e;
        head_n  = head_e + n_e;
        len_n   = len_e - n_e;
      end
      default: begin
        dec_err = 1'b1;
      end
    endcase
    if (dec_err || !accept) begin
      req.wr = 1'b0;
      req.rd = 1'b0;
      head_n = head_e;
      len_n  = len_e;
    end
  end

  // Writes land at the accept edge and reads follow no earlier than the next
  // accept, so no bank sees a same-entry read/write overlap.
  pbht_store #(.BUF_BYTES(BUF_BYTES), .AW(AW)) u_store (
    .clk   (clk),
    .req   (req),
    .addr  (addr_e[AW-1:0]),
    .wdata (in_ch.write_data),
    .rdata (store_q)
  );

  always_comb begin
    state_nxt = state_r;
    accept    = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        accept = in_ch.valid;
        if (in_ch.valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        out_load = !out_valid_r || out_ch.ready;
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    out_valid_nxt = out_load || (out_valid_r && !out_ch.ready);
  end

  assign in_ch.ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      headroom_r  <= HEADROOM_RST;
      head_r      <= CW'(HEAD_RST);
      len_r       <= '0;
      out_valid_r <= 1'b0;
      pend_rd_r   <= 1'b0;
      pend_err_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        headroom_r <= cfg_wdata;
      end
      if (accept) begin
        head_r     <= CW'(head_n);
        len_r      <= CW'(len_n);
        pend_rd_r  <= req.rd;
        pend_err_r <= dec_err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rd_r   <= pend_rd_r ? store_q : '0;
      out_err_r  <= pend_err_r;
      out_room_r <= LEN_OUT_W'(BUF_E - (head_e + len_e));
      out_len_r  <= LEN_OUT_W'(len_r);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_data  = out_rd_r;
  assign out_ch.error      = out_err_r;
  assign out_ch.room_left  = out_room_r;
  assign out_ch.msg_length = out_len_r;

  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == ST_EXEC))
    else $error("accepted transaction did not enter the execute cycle");

  a_msg_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (head_e + len_e) <= BUF_E)
    else $error("message tail beyond buffer end");

  a_err_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (out_rd_r == '0))
    else $error("refused command returned data");

  a_err_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && dec_err) |=> (head_r == $past(head_r)) && (len_r == $past(len_r)))
    else $error("refused command changed head or length");

  a_no_read_when_err: assert property (@(posedge clk) disable iff (!rst_n)
    pend_err_r |-> !pend_rd_r)
    else $error("store read issued for a refused command");

endmodule

// ----- sv/pbht_bank.sv -----
// One byte-wide bank of the store: single port, registered read data.
// No package dependencies.
module pbht_bank #(
  parameter int DEPTH = 256,
  parameter int RW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic          re,
  input  logic [RW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/pbht_store.sv -----
// Byte store split into eight banks by address bits [2:0], so any run of up
// to six consecutive bytes hits distinct banks. Depends on pbht_pkg, pbht_bank.
module pbht_store #(
  parameter int BUF_BYTES = 2048,
  parameter int AW        = 11
) (
  input  logic                        clk,
  input  pbht_pkg::store_req_t        req,
  input  logic [AW-1:0]               addr,
  input  logic [pbht_pkg::DATA_W-1:0] wdata,
  output logic [pbht_pkg::DATA_W-1:0] rdata
);
  import pbht_pkg::*;

  localparam int ROWS = (BUF_BYTES + NBANK - 1) / NBANK;
  localparam int RW   = AW - BANK_SEL_W;

  logic [BANK_SEL_W-1:0] off;
  logic [RW-1:0]         base_row;
  logic [63:0]           wd_ext;
  logic [7:0]            bank_q [NBANK];
  logic [BANK_SEL_W-1:0] off_r;
  logic [NBYTE_W-1:0]    n_r;

  assign off      = addr[BANK_SEL_W-1:0];
  assign base_row = addr[AW-1:BANK_SEL_W];
  assign wd_ext   = {{(64-DATA_W){1'b0}}, wdata};

  for (genvar b = 0; b < NBANK; b++) begin : g_bank
    logic [BANK_SEL_W-1:0] idx;
    logic [NBYTE_W-1:0]    k;
    logic                  en;
    logic [RW-1:0]         row;
    logic [7:0]            wbyte;

    // byte idx of the transfer lands here; lower banks take the next row
    assign idx   = BANK_SEL_W'(b) - off;
    assign en    = idx < req.nbytes;
    assign row   = base_row + RW'(BANK_SEL_W'(b) < off);
    assign k     = req.nbytes - NBYTE_W'(1) - idx;
    assign wbyte = wd_ext[{k, 3'b000} +: 8];

    pbht_bank #(.DEPTH(ROWS), .RW(RW)) u_bank (
      .clk   (clk),
      .we    (req.wr && en),
      .re    (req.rd && en),
      .addr  (row),
      .wdata (wbyte),
      .rdata (bank_q[b])
    );
  end

  always_ff @(posedge clk) begin
    if (req.rd) begin
      off_r <= off;
      n_r   <= req.nbytes;
    end
  end

  // Reassemble MSB first, right aligned
  always_comb begin
    logic [NBYTE_W-1:0]    i;
    logic [BANK_SEL_W-1:0] bsel;
    rdata = '0;
    for (int p = 0; p < DATA_W / 8; p++) begin
      i    = n_r - NBYTE_W'(1) - NBYTE_W'(p);
      bsel = off_r + BANK_SEL_W'(i);
      if (NBYTE_W'(p) < n_r) begin
        rdata[p*8 +: 8] = bank_q[bsel];
      end
    end
  end

endmodule

// ----- bench/tb_packet_buffer_head_tail_engine_top.sv -----
// Self-checking bench for packet_buffer_head_tail_engine_top: directed tests of empty and undefined
// commands, header build, bounds and sizes, strip, headroom edges and back-pressure, then random
// command traffic under several headrooms. Depends on pbht_pkg, pbht_if and the RTL top level.
module tb_packet_buffer_head_tail_engine_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pbht_pkg::*;

  localparam int BUF_BYTES = 2048;
  localparam int STALL_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 4;
  localparam int REPORT_CAP = 100;
  localparam logic [2:0] CMD_UNDEF = 3'd7;

  typedef struct {
    logic [DATA_W-1:0]    read_data;
    logic                 error;
    logic [LEN_OUT_W-1:0] room_left;
    logic [LEN_OUT_W-1:0] msg_length;
  } buf_outcome_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [HR_W-1:0] cfg_wdata;

  pbht_in_if  in_ch ();
  pbht_out_if out_ch ();

  packet_buffer_head_tail_engine_top #(.BUF_BYTES(BUF_BYTES)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the buffer
  logic [7:0]  shadow_mem [BUF_BYTES];
  int unsigned shadow_head;
  int unsigned shadow_len;
  int unsigned shadow_headroom;

  buf_outcome_t pending_outcomes [$];
  int mismatch_count = 0;
  int idle_cycles = 0;
  int sink_hold = 0;
  bit quiet = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit legal_size(input logic [CNT_W-1:0] n);
    return (n == 8'd1) || (n == 8'd2) || (n == 8'd4) || (n == 8'd6);
  endfunction

  // Big-endian: lowest address holds the most significant byte
  function automatic void put_bytes(input int unsigned addr, input int unsigned n,
                                    input logic [DATA_W-1:0] wd);
    int unsigned i;
    for (i = 0; i < n; i++) begin
      shadow_mem[addr + i] = 8'(wd >> (8 * (n - 1 - i)));
    end
  endfunction

  function automatic logic [DATA_W-1:0] fetch_bytes(input int unsigned addr,
                                                    input int unsigned n);
    logic [DATA_W-1:0] v;
    int unsigned i;
    v = '0;
    for (i = 0; i < n; i++) begin
      v = {v[DATA_W-9:0], shadow_mem[addr + i]};
    end
    return v;
  endfunction

  function automatic buf_outcome_t apply_buffer_cmd(input logic [2:0] op,
                                                    input logic [CNT_W-1:0] n,
                                                    input logic [DATA_W-1:0] wd,
                                                    input logic [POS_W-1:0] pos);
    buf_outcome_t r;
    logic [DATA_W-1:0] rd;
    bit refused;
    bit sz;
    int unsigned tail;
    rd = '0;
    refused = 1'b0;
    sz = legal_size(n);
    tail = shadow_head + shadow_len;
    case (op)
      CMD_CLEAR: begin
        shadow_head = (shadow_headroom > BUF_BYTES) ? BUF_BYTES : shadow_headroom;
        shadow_len = 0;
      end
      CMD_PUSH: begin
        if (!sz || shadow_head < n) refused = 1'b1;
        else begin
          shadow_head -= n;
          shadow_len += n;
          put_bytes(shadow_head, n, wd);
        end
      end
      CMD_APPEND: begin
        if (!sz || tail + n > BUF_BYTES) refused = 1'b1;
        else begin
          put_bytes(tail, n, wd);
          shadow_len += n;
        end
      end
      CMD_POKE: begin
        if (!sz || pos + n > shadow_len) refused = 1'b1;
        else put_bytes(shadow_head + pos, n, wd);
      end
      CMD_POP: begin
        if (!sz || shadow_len < n) refused = 1'b1;
        else begin
          rd = fetch_bytes(shadow_head, n);
          shadow_head += n;
          shadow_len -= n;
        end
      end
      CMD_READ: begin
        if (!sz || pos + n > shadow_len) refused = 1'b1;
        else rd = fetch_bytes(shadow_head + pos, n);
      end
      CMD_SKIP: begin
        if (shadow_len < n) refused = 1'b1;
        else begin
          shadow_head += n;
          shadow_len -= n;
        end
      end
      default: refused = 1'b1;
    endcase
    r.read_data = refused ? '0 : rd;
    r.error = refused;
    r.room_left = LEN_OUT_W'(BUF_BYTES - (shadow_head + shadow_len));
    r.msg_length = LEN_OUT_W'(shadow_len);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    mismatch_count++;
    if (mismatch_count <= REPORT_CAP)
      $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
  endtask

  // Entered and left at a falling edge; valid stays high after acceptance
  task automatic send_cmd(input logic [2:0] op, input logic [CNT_W-1:0] n,
                          input logic [DATA_W-1:0] wd, input logic [POS_W-1:0] pos);
    while (!quiet && $urandom_range(99) < 9) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.cmd = op;
    in_ch.byte_count = n;
    in_ch.write_data = wd;
    in_ch.position = pos;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    pending_outcomes.push_back(apply_buffer_cmd(op, n, wd, pos));
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_ch.valid = 1'b0;
    while (pending_outcomes.size() != 0) @(negedge clk);
  endtask

  task automatic set_headroom(input logic [HR_W-1:0] v);
    wait_drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    shadow_headroom = v;
  endtask

  function automatic logic [CNT_W-1:0] pick_size();
    if ($urandom_range(19) == 0) return CNT_W'($urandom_range(255));
    case ($urandom_range(3))
      0: return 8'd1;
      1: return 8'd2;
      2: return 8'd4;
      default: return 8'd6;
    endcase
  endfunction

  // Mostly well-formed transactions against the current message, some noise
  task automatic send_random(input bit grow);
    int pick;
    int unsigned lim;
    logic [2:0] op;
    logic [CNT_W-1:0] n;
    logic [63:0] r64;
    logic [POS_W-1:0] pos;
    pick = $urandom_range(99);
    if (grow && pick >= 52 && pick < 66 && $urandom_range(2) != 0) pick = 30;
    if (pick < 3) op = CMD_CLEAR;
    else if (pick < 20) op = CMD_PUSH;
    else if (pick < 40) op = CMD_APPEND;
    else if (pick < 52) op = CMD_POKE;
    else if (pick < 66) op = CMD_POP;
    else if (pick < 82) op = CMD_READ;
    else if (pick < 96) op = CMD_SKIP;
    else op = 3'($urandom_range(7));
    n = pick_size();
    if (op == CMD_SKIP) begin
      lim = (shadow_len > 255) ? 255 : shadow_len;
      if (lim > 24 && $urandom_range(3) != 0) lim = 24;
      n = (lim == 0 || $urandom_range(7) == 0) ? CNT_W'($urandom_range(255))
                                               : CNT_W'($urandom_range(lim));
    end
    if (shadow_len >= n && $urandom_range(9) != 0)
      pos = POS_W'($urandom_range(shadow_len - n));
    else
      pos = POS_W'($urandom_range(2047));
    r64 = {$urandom, $urandom};
    send_cmd(op, n, r64[DATA_W-1:0], pos);
  endtask

  task automatic run_random(input int count, input bit grow);
    int k;
    send_cmd(CMD_CLEAR, '0, '0, '0);
    for (k = 0; k < count; k++) send_random(grow);
  endtask

  task automatic test_empty_and_undefined();
    send_cmd(CMD_READ, 8'd1, '0, 11'd0);
    send_cmd(CMD_UNDEF, 8'hFF, '1, '1);
  endtask

  task automatic test_header_build();
    send_cmd(CMD_APPEND, 8'd6, 48'h0123_4567_89AB, '0);
    send_cmd(CMD_PUSH, 8'd2, 48'hFFFF_FFFF_A55A, '0);
    send_cmd(CMD_PUSH, 8'd1, 48'hFFFF_FFFF_FF80, '0);
    send_cmd(CMD_PUSH, 8'd4, 48'hFFFF_DEAD_BEEF, '0);
    send_cmd(CMD_READ, 8'd6, '0, 11'd0);
    send_cmd(CMD_READ, 8'd6, '0, 11'd7);
    send_cmd(CMD_POKE, 8'd2, 48'h0000_0000_C3C3, 11'd11);
  endtask

  task automatic test_bounds_and_sizes();
    send_cmd(CMD_READ, 8'd6, '0, 11'd8);
    send_cmd(CMD_POKE, 8'd2, '1, 11'd12);
    send_cmd(CMD_READ, 8'd1, '0, 11'd2047);
    send_cmd(CMD_APPEND, 8'd3, '1, '0);
    send_cmd(CMD_PUSH, 8'd0, '1, '0);
    send_cmd(CMD_READ, 8'd255, '0, '0);
  endtask

  task automatic test_strip();
    send_cmd(CMD_POP, 8'd6, '0, '0);
    send_cmd(CMD_SKIP, 8'd0, '0, '0);
    send_cmd(CMD_SKIP, 8'd255, '0, '0);
    send_cmd(CMD_SKIP, 8'd3, '0, '0);
    send_cmd(CMD_POP, 8'd4, '0, '0);
    send_cmd(CMD_POP, 8'd1, '0, '0);
    send_cmd(CMD_CLEAR, 8'hA5, '1, '1);
  endtask

  task automatic test_headroom_edges();
    set_headroom(12'd2);
    send_cmd(CMD_CLEAR, '0, '0, '0);
    send_cmd(CMD_PUSH, 8'd4, 48'h1111_2222_3333, '0);
    send_cmd(CMD_PUSH, 8'd2, 48'h0000_0000_7E7E, '0);
    send_cmd(CMD_PUSH, 8'd1, '1, '0);
    set_headroom(12'd2042);
    send_cmd(CMD_CLEAR, '0, '0, '0);
    send_cmd(CMD_APPEND, 8'd6, 48'hFEDC_BA98_7654, '0);
    send_cmd(CMD_APPEND, 8'd1, '1, '0);
    send_cmd(CMD_READ, 8'd6, '0, 11'd0);
    // clear clamps an oversized headroom to the buffer size
    set_headroom(12'd4095);
    send_cmd(CMD_CLEAR, '0, '0, '0);
    send_cmd(CMD_PUSH, 8'd6, 48'h0F0F_F0F0_5A5A, '0);
  endtask

  task automatic test_backpressure();
    int k;
    send_cmd(CMD_CLEAR, '0, '0, '0);
    quiet = 1'b1;
    sink_hold = 150;
    for (k = 0; k < 30; k++) send_random(1'b1);
    quiet = 1'b0;
    // sender pauses until the block has handed everything back
    wait_drain();
  endtask

  task automatic test_random_traffic();
    set_headroom(12'd0);
    run_random(230, 1'b1);
    set_headroom(12'd2048);
    run_random(200, 1'b0);
    set_headroom(12'd1024);
    run_random(250, 1'b0);
    set_headroom(HR_W'($urandom_range(2048)));
    run_random(250, 1'b1);
    set_headroom(12'd4095);
    run_random(100, 1'b0);
    set_headroom(HEADROOM_RST);
    quiet = 1'b1;
    run_random(100, 1'b1);
    quiet = 1'b0;
    run_random(150, 1'b0);
  endtask

  always @(negedge clk) begin
    if (sink_hold > 0) begin
      out_ch.ready = 1'b0;
      sink_hold--;
    end else begin
      out_ch.ready = quiet || ($urandom_range(99) >= 9);
    end
  end

  always @(posedge clk) begin
    buf_outcome_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("unexpected result", out_ch.read_data, '0);
      end else begin
        want = pending_outcomes.pop_front();
        if (out_ch.read_data !== want.read_data)
          report_mismatch("read_data", out_ch.read_data, want.read_data);
        if (out_ch.error !== want.error)
          report_mismatch("error", DATA_W'(out_ch.error), DATA_W'(want.error));
        if (out_ch.room_left !== want.room_left)
          report_mismatch("room_left", DATA_W'(out_ch.room_left), DATA_W'(want.room_left));
        if (out_ch.msg_length !== want.msg_length)
          report_mismatch("msg_length", DATA_W'(out_ch.msg_length),
                          DATA_W'(want.msg_length));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_CLEAR;
    in_ch.byte_count = '0;
    in_ch.write_data = '0;
    in_ch.position = '0;
    out_ch.ready = 1'b1;
    shadow_headroom = HEADROOM_RST;
    shadow_head = HEADROOM_RST;
    shadow_len = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    test_empty_and_undefined();
    test_header_build();
    test_bounds_and_sizes();
    test_strip();
    test_headroom_edges();
    test_backpressure();
    test_random_traffic();

    wait_drain();
    repeat (SETTLE_CYCLES + 2) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
